// ===== rtl/acotd_pkg.sv =====
// types, constants and helpers shared by the alarm clock time of day block
package acotd_pkg;

    localparam logic [16:0] DAY_SECONDS    = 17'd86400;
    localparam logic [16:0] HOUR_SECONDS   = 17'd3600;
    localparam logic [16:0] MINUTE_SECONDS = 17'd60;
    localparam logic [4:0]  HALF_DAY_HOURS = 5'd12;

    // reciprocals for constant division, estimate is exact or one low
    localparam logic [15:0] HOUR_RECIP   = 16'd18641;
    localparam int          HOUR_SHIFT   = 26;
    localparam logic [10:0] MINUTE_RECIP = 11'd1092;
    localparam int          MINUTE_SHIFT = 16;

    typedef enum logic [1:0] {
        BTN_NONE       = 2'd0,
        BTN_ADD_MINUTE = 2'd1,
        BTN_ADD_HOUR   = 2'd2,
        BTN_SUB_MINUTE = 2'd3
    } button_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_ENABLE_ZERO  = 2'd1,
        STATUS_DISABLE_ZERO = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_COUNT      = 3'd0,
        OP_HOLD       = 3'd1,
        OP_EDIT_ALARM = 3'd2,
        OP_EDIT_TIME  = 3'd3,
        OP_ARM_ONLY   = 3'd4
    } op_kind_t;

    typedef struct packed {
        logic       command;
        logic [1:0] buttons;
        logic       alarm_enable;
        logic       edit_alarm;
        logic       edit_time;
        logic       twelve_hour;
    } item_t;

    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] minute_tens;
        logic [3:0] minute_units;
        logic [2:0] second_tens;
        logic [3:0] second_units;
        logic       pm;
        logic       ring;
        logic       armed;
        logic [1:0] status;
    } result_t;

    // classified word passed from front to back
    typedef struct packed {
        op_kind_t kind;
        button_t  delta;
        logic     enable;
        logic     show_alarm;
        logic     twelve_hour;
    } op_t;

    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] units;
    } bcd60_t;

    // value below 60 into two bcd digits
    function automatic bcd60_t to_bcd60(input logic [5:0] v);
        bcd60_t d;
        if (v >= 6'd50)
            d.tens = 3'd5;
        else if (v >= 6'd40)
            d.tens = 3'd4;
        else if (v >= 6'd30)
            d.tens = 3'd3;
        else if (v >= 6'd20)
            d.tens = 3'd2;
        else if (v >= 6'd10)
            d.tens = 3'd1;
        else
            d.tens = 3'd0;
        d.units = 4'(v - 6'(d.tens) * 6'd10);
        return d;
    endfunction

endpackage

// ===== rtl/alarm_clock_time_of_day_core.sv =====
// Alarm clock with a seconds-of-day counter and alarm time, shown as bcd hh:mm:ss.
// One word is accepted per clock cycle while the queue is not full, and one result word
// per cycle can be taken while results are ready; the rate is set by the time and alarm
// update at the head of the back end. A word passes through the operation queue and a
// six-stage back end to the result ports. The queue of QUEUE_DEPTH words lets input
// continue while results wait to be popped.
module alarm_clock_time_of_day_core
    import acotd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    push,
    output logic    full,
    output result_t result,
    output logic    empty,
    input  logic    pop
);

    op_t  front_op, queue_op;
    logic queue_empty, queue_pop;

    acotd_front u_front (
        .item (item),
        .op   (front_op)
    );

    acotd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_op),
        .full    (full),
        .rd_en   (queue_pop),
        .rd_data (queue_op),
        .empty   (queue_empty)
    );

    acotd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (queue_op),
        .op_empty (queue_empty),
        .op_pop   (queue_pop),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

    // ring only comes from count and hold words, error status only from command words
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(result.ring && result.status != STATUS_OK))
        else $error("ring and error status in the same word");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.hour_tens <= 2'd2 && result.minute_tens <= 3'd5
                    && result.second_tens <= 3'd5 && result.minute_units <= 4'd9
                    && result.second_units <= 4'd9 && result.hour_units <= 4'd9))
        else $error("bcd digit out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.pm) |->
            (result.hour_tens == 2'd0
             || (result.hour_tens == 2'd1 && result.hour_units <= 4'd1)))
        else $error("pm set with an hour of twelve or more");

endmodule

// ===== rtl/acotd_front.sv =====
// front end: classifies an incoming word into an operation for the back end
module acotd_front
    import acotd_pkg::*;
(
    input  item_t item,
    output op_t   op
);

    always_comb
    begin
        op.delta       = button_t'(item.buttons);
        op.enable      = item.alarm_enable;
        op.show_alarm  = item.edit_alarm;
        op.twelve_hour = item.twelve_hour;
        if (!item.command)
            op.kind = item.edit_time ? OP_HOLD : OP_COUNT;
        else if (item.edit_alarm)
            op.kind = OP_EDIT_ALARM;
        else if (item.edit_time)
            op.kind = OP_EDIT_TIME;
        else
            op.kind = OP_ARM_ONLY;
    end

endmodule

// ===== rtl/acotd_queue.sv =====
// small fifo of classified operations between front and back
module acotd_queue
    import acotd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  op_t  wr_data,
    output logic full,
    input  logic rd_en,
    output op_t  rd_data,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/acotd_back.sv =====
// back end: time and alarm state, then a pipeline that converts the shown time or alarm to bcd
module acotd_back
    import acotd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  op_t     op,
    input  logic    op_empty,
    output logic    op_pop,
    output result_t result,
    output logic    empty,
    input  logic    pop
);

    typedef struct packed {
        logic       ring;
        logic       armed;
        logic [1:0] status;
        logic       twelve_hour;
    } side_t;

    logic [16:0] time_reg, time_next;
    logic [16:0] alarm_reg, alarm_next;
    logic        armed_reg, armed_next;

    logic [6:1]  valid_reg;
    logic        advance;

    side_t       side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    side_t       side1_next;
    logic [16:0] shown1_reg, shown2_reg, shown1_next;
    logic [4:0]  hest2_reg;
    logic [4:0]  hours3_reg, hours4_reg, hours5_reg;
    logic [11:0] rem3_reg, rem4_reg;
    logic [5:0]  mest4_reg;
    logic [5:0]  minutes5_reg, seconds5_reg;
    logic        pm5_reg;
    result_t     result_reg;

    logic [16:0] tick_sum;
    logic        alarm_zero;

    function automatic logic [16:0] edit_value(input logic [16:0] v, input button_t b);
        logic [16:0] r;
        r = v;
        case (b)
            BTN_ADD_MINUTE: r = v + MINUTE_SECONDS;
            BTN_ADD_HOUR:   r = v + HOUR_SECONDS;
            BTN_SUB_MINUTE: r = (v < MINUTE_SECONDS) ? DAY_SECONDS : v - MINUTE_SECONDS;
            default:        r = v;
        endcase
        if (r >= DAY_SECONDS)
            r = '0;
        return r;
    endfunction

    // whole pipeline holds while the finished word is not taken
    assign advance = !(valid_reg[6] && !pop);
    assign op_pop  = advance && !op_empty;
    assign empty   = !valid_reg[6];
    assign result  = result_reg;

    // stage 1: state update
    always_comb
    begin
        time_next   = time_reg;
        alarm_next  = alarm_reg;
        armed_next  = armed_reg;
        tick_sum    = time_reg + {16'd0, (op.kind == OP_COUNT)};
        alarm_zero  = (alarm_reg == '0);
        side1_next.ring        = 1'b0;
        side1_next.status      = STATUS_OK;
        side1_next.twelve_hour = op.twelve_hour;
        case (op.kind)
            OP_COUNT, OP_HOLD:
            begin
                side1_next.ring = armed_reg && (tick_sum == alarm_reg);
                time_next       = (tick_sum >= DAY_SECONDS) ? '0 : tick_sum;
            end
            OP_EDIT_ALARM, OP_EDIT_TIME, OP_ARM_ONLY:
            begin
                if (alarm_zero)
                    side1_next.status = op.enable ? STATUS_ENABLE_ZERO : STATUS_DISABLE_ZERO;
                else
                    armed_next = op.enable;
                if (op.kind == OP_EDIT_ALARM)
                    alarm_next = edit_value(alarm_reg, op.delta);
                else if (op.kind == OP_EDIT_TIME)
                    time_next = edit_value(time_reg, op.delta);
            end
            default:
            begin
                time_next = time_reg;
            end
        endcase
        side1_next.armed = armed_next;
        shown1_next      = op.show_alarm ? alarm_next : time_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            alarm_reg <= '0;
            armed_reg <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            if (op_pop)
            begin
                time_reg  <= time_next;
                alarm_reg <= alarm_next;
                armed_reg <= armed_next;
            end
            if (advance)
                valid_reg <= {valid_reg[5:1], !op_empty};
        end
    end

    logic [31:0] h_prod;
    logic [16:0] h_back, rem3_full;
    logic [21:0] m_prod;
    logic [11:0] m_back, rem5_full;
    logic [4:0]  hours_fold;
    bcd60_t      hour_bcd, minute_bcd, second_bcd;

    always_comb
    begin
        h_prod    = 32'(shown1_reg) * 32'(HOUR_RECIP);
        h_back    = 17'(hest2_reg) * HOUR_SECONDS;
        rem3_full = shown2_reg - h_back;
        m_prod    = 22'(rem3_reg) * 22'(MINUTE_RECIP);
        m_back    = 12'(mest4_reg) * 12'(MINUTE_SECONDS);
        rem5_full = rem4_reg - m_back;
        hours_fold = (side4_reg.twelve_hour && hours4_reg >= HALF_DAY_HOURS)
                   ? hours4_reg - HALF_DAY_HOURS : hours4_reg;
        hour_bcd   = to_bcd60({1'b0, hours5_reg});
        minute_bcd = to_bcd60(minutes5_reg);
        second_bcd = to_bcd60(seconds5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side1_reg  <= side1_next;
            shown1_reg <= shown1_next;

            side2_reg  <= side1_reg;
            shown2_reg <= shown1_reg;
            hest2_reg  <= 5'(h_prod >> HOUR_SHIFT);

            side3_reg  <= side2_reg;
            if (rem3_full >= HOUR_SECONDS)
            begin
                hours3_reg <= hest2_reg + 1'b1;
                rem3_reg   <= 12'(rem3_full - HOUR_SECONDS);
            end
            else
            begin
                hours3_reg <= hest2_reg;
                rem3_reg   <= 12'(rem3_full);
            end

            side4_reg  <= side3_reg;
            hours4_reg <= hours3_reg;
            rem4_reg   <= rem3_reg;
            mest4_reg  <= 6'(m_prod >> MINUTE_SHIFT);

            side5_reg  <= side4_reg;
            hours5_reg <= hours_fold;
            pm5_reg    <= side4_reg.twelve_hour && (hours4_reg >= HALF_DAY_HOURS);
            if (rem5_full >= 12'(MINUTE_SECONDS))
            begin
                minutes5_reg <= mest4_reg + 1'b1;
                seconds5_reg <= 6'(rem5_full - 12'(MINUTE_SECONDS));
            end
            else
            begin
                minutes5_reg <= mest4_reg;
                seconds5_reg <= 6'(rem5_full);
            end

            result_reg.hour_tens    <= 2'(hour_bcd.tens);
            result_reg.hour_units   <= hour_bcd.units;
            result_reg.minute_tens  <= minute_bcd.tens;
            result_reg.minute_units <= minute_bcd.units;
            result_reg.second_tens  <= second_bcd.tens;
            result_reg.second_units <= second_bcd.units;
            result_reg.pm           <= pm5_reg;
            result_reg.ring         <= side5_reg.ring;
            result_reg.armed        <= side5_reg.armed;
            result_reg.status       <= side5_reg.status;
        end
    end

endmodule
